@@ rtl/core/qlmg_pkg.sv @@
// shared constants, types and tables for the qr-like module generator
package qlmg_pkg;

    // coordinate field width and symbol geometry
    localparam int COORD_W    = 5;
    localparam int COORD_N    = 2 ** COORD_W;
    localparam int SIDE       = 29;
    localparam int MASK_BLOCK = 5;

    // format register
    localparam int FORMAT_W = 15;
    localparam logic [FORMAT_W-1:0] FORMAT_RESET = FORMAT_W'(21165);

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_FORMAT_WORD = 1'b0;

    // one result transaction
    typedef struct packed {
        logic module_bit;
        logic is_reserved;
    } result_t;

    // parity of coord / MASK_BLOCK for every coordinate value
    function automatic logic [COORD_N-1:0] mask_parity_table();
        logic [COORD_N-1:0] t;
        t = '0;
        for (int i = 0; i < COORD_N; i++)
        begin
            t[i] = ((i / MASK_BLOCK) % 2) != 0;
        end
        return t;
    endfunction

    localparam logic [COORD_N-1:0] MASK_PARITY = mask_parity_table();

endpackage

@@ rtl/core/qlmg_cfg.sv @@
// apb configuration register holding the format word
module qlmg_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qlmg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qlmg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qlmg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [qlmg_pkg::FORMAT_W-1:0]       format_word
);

    logic [qlmg_pkg::FORMAT_W-1:0] format_reg;
    logic [qlmg_pkg::FORMAT_W-1:0] format_next;
    logic                          wr_en;
    logic                          sel_format;

    assign pready     = 1'b1;
    assign sel_format = (paddr[2] == qlmg_pkg::REG_FORMAT_WORD);
    assign wr_en      = psel && penable && pwrite && pready && sel_format;

    // format register update, upper data bits dropped
    always_comb
    begin
        format_next = format_reg;
        if (wr_en)
        begin
            format_next = pwdata[qlmg_pkg::FORMAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= qlmg_pkg::FORMAT_RESET;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (sel_format)
        begin
            prdata = qlmg_pkg::APB_DATA_W'(format_reg);
        end
    end

    assign format_word = format_reg;

endmodule

@@ rtl/core/qlmg_pattern.sv @@
// function pattern lookup and data masking for one module position
module qlmg_pattern (
    input  logic [qlmg_pkg::COORD_W-1:0]    row,
    input  logic [qlmg_pkg::COORD_W-1:0]    col,
    input  logic                            data_bit,
    input  logic [qlmg_pkg::FORMAT_W-1:0]   format_word,
    output qlmg_pkg::result_t               result
);

    localparam int CW = qlmg_pkg::COORD_W;
    localparam int N  = qlmg_pkg::SIDE;

    localparam logic [CW-1:0] N_M1 = CW'(N - 1);
    localparam logic [CW-1:0] N_M5 = CW'(N - 5);
    localparam logic [CW-1:0] N_M8 = CW'(N - 8);
    localparam logic [CW-1:0] N_M9 = CW'(N - 9);
    localparam logic [CW-1:0] N_C  = CW'(N);

    // finder with separator, a and b measured from the outer corner
    function automatic logic finder_value(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic v;
        v = 1'b0;
        if (a >= CW'(7) || b >= CW'(7))
        begin
            v = 1'b0;
        end
        else if (a == CW'(0) || a == CW'(6) || b == CW'(0) || b == CW'(6))
        begin
            v = 1'b1;
        end
        else if (a >= CW'(2) && a <= CW'(4) && b >= CW'(2) && b <= CW'(4))
        begin
            v = 1'b1;
        end
        return v;
    endfunction

    // alignment square, a and b measured from its top-left corner
    function automatic logic align_value(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic v;
        v = (a == CW'(0)) || (a == CW'(4)) || (b == CW'(0)) || (b == CW'(4))
            || ((a == CW'(2)) && (b == CW'(2)));
        return v;
    endfunction

    logic [3:0] fmt_idx;
    logic       fmt_hit;
    logic       mask_bit;

    // format position decode
    always_comb
    begin
        fmt_idx = 4'd0;
        fmt_hit = 1'b0;
        priority if (col == CW'(8) && row <= CW'(5))
        begin
            fmt_idx = 4'(CW'(7) - row);
            fmt_hit = 1'b1;
        end
        else if (col == CW'(8) && row == CW'(7))
        begin
            fmt_idx = 4'd1;
            fmt_hit = 1'b1;
        end
        else if (row == CW'(8) && col == CW'(8))
        begin
            fmt_idx = 4'd0;
            fmt_hit = 1'b1;
        end
        else if (row == CW'(8) && col >= N_M8 && col <= N_M1)
        begin
            fmt_idx = 4'(N_M1 - col);
            fmt_hit = 1'b1;
        end
        else if ((row == CW'(8) || row == N_M9) && col <= CW'(5))
        begin
            fmt_idx = 4'(col + CW'(8));
            fmt_hit = 1'b1;
        end
        else if ((row == CW'(8) || row == N_M9) && col == CW'(7))
        begin
            fmt_idx = 4'd14;
            fmt_hit = 1'b1;
        end
        else
        begin
            fmt_idx = 4'd0;
            fmt_hit = 1'b0;
        end
    end

    // block checkerboard mask
    assign mask_bit = ~(qlmg_pkg::MASK_PARITY[row] ^ qlmg_pkg::MASK_PARITY[col]);

    // pattern priority: out-of-range positions, format, timing, alignment, finders, then masked data
    always_comb
    begin
        result.module_bit  = 1'b0;
        result.is_reserved = 1'b1;
        priority if (row >= N_C || col >= N_C)
        begin
            result.module_bit  = 1'b0;
            result.is_reserved = 1'b0;
        end
        else if (fmt_hit)
        begin
            result.module_bit = format_word[fmt_idx];
        end
        else if (row == CW'(6) && col >= CW'(8) && col <= N_M9)
        begin
            result.module_bit = ~col[0];
        end
        else if (col == CW'(6) && row >= CW'(8) && row <= N_M9)
        begin
            result.module_bit = ~row[0];
        end
        else if (row >= N_M9 && row <= N_M5 && col >= N_M9 && col <= N_M5)
        begin
            result.module_bit = align_value(row - N_M9, col - N_M9);
        end
        else if (row < CW'(8) && col < CW'(8))
        begin
            result.module_bit = finder_value(row, col);
        end
        else if (row >= N_M8 && col < CW'(8))
        begin
            result.module_bit = finder_value(N_M1 - row, col);
        end
        else if (row < CW'(8) && col >= N_M8)
        begin
            result.module_bit = finder_value(row, N_M1 - col);
        end
        else
        begin
            result.module_bit  = data_bit ^ mask_bit;
            result.is_reserved = 1'b0;
        end
    end

endmodule

@@ rtl/core/qr_like_module_generator.sv @@
// top level: input register, pattern logic, result register, config port
// throughput: one transaction per cycle while the result side is not stalled, set by
// the single pattern lookup between two registers
// item_stall rises only while both the input register and the result register hold data
// reset (rst_n low, asynchronous) empties both registers and loads the format word default
module qr_like_module_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [qlmg_pkg::COORD_W-1:0]        row,
    input  logic [qlmg_pkg::COORD_W-1:0]        col,
    input  logic                                data_bit,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                module_bit,
    output logic                                is_reserved,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qlmg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qlmg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qlmg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [qlmg_pkg::FORMAT_W-1:0] format_word;

    logic                          in_valid_reg;
    logic [qlmg_pkg::COORD_W-1:0]  row_reg;
    logic [qlmg_pkg::COORD_W-1:0]  col_reg;
    logic                          data_reg;

    logic                          out_valid_reg;
    qlmg_pkg::result_t             out_reg;
    qlmg_pkg::result_t             result_next;

    logic                          out_load;
    logic                          in_load;

    // configuration register
    qlmg_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .format_word (format_word)
    );

    // pipeline advance
    assign out_load   = !out_valid_reg || !result_stall;
    assign in_load    = !in_valid_reg || out_load;
    assign item_stall = !in_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && item_valid)
        begin
            row_reg  <= row;
            col_reg  <= col;
            data_reg <= data_bit;
        end
    end

    // pattern lookup
    qlmg_pattern u_pattern (
        .row         (row_reg),
        .col         (col_reg),
        .data_bit    (data_reg),
        .format_word (format_word),
        .result      (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign module_bit   = out_reg.module_bit;
    assign is_reserved  = out_reg.is_reserved;

endmodule

@@ rtl/core/qlmg_checker.sv @@
// port-level checker for the qr-like module generator, bound to the top level
module qlmg_checker (
    input logic clk,
    input logic rst_n,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic module_bit,
    input logic is_reserved
);

    // input side backs up only when a result is waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item_stall high with no result held");

    // input side backs up only when the output side is stalled
    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_stall)
        else $error("item_stall high while result side is free");

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result_valid high right after reset");

    // held result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(module_bit) && $stable(is_reserved))
        else $error("stalled result changed");

endmodule

bind qr_like_module_generator qlmg_checker u_qlmg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .module_bit   (module_bit),
    .is_reserved  (is_reserved)
);
